/* hdl/satc_pkg.sv */
// Shared types and constants for the sorted adjacency triangle counter.
package satc_pkg;

	localparam int NODE_W = 10;
	localparam int IDX_W  = 6;
	localparam int LEN_W  = 7;
	localparam int ADDR_W = NODE_W + IDX_W;
	localparam int CNT_W  = 13;
	localparam int SUM_W  = 22;
	localparam int TOT_W  = 17;
	localparam int NC_W   = 11;

	localparam logic [NC_W-1:0]  MAX_NODES  = 11'd1024;
	localparam logic [LEN_W-1:0] MAX_DEGREE = 7'd64;
	localparam logic [CNT_W-1:0] NODE_SAT   = 13'd8191;
	localparam logic [SUM_W-1:0] TOTAL_SAT  = 22'd4194303;

	localparam logic [2:0] MODE_ADD    = 3'd0;
	localparam logic [2:0] MODE_REMOVE = 3'd1;
	localparam logic [2:0] MODE_FIND   = 3'd2;
	localparam logic [2:0] MODE_COUNT  = 3'd3;
	localparam logic [2:0] MODE_READ   = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SELF     = 3'd1;
	localparam logic [2:0] ST_DUP      = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;
	localparam logic [2:0] ST_RANGE    = 3'd5;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_LEN, S_LEN_W, S_SCAN, S_SCAN_W,
		S_ISHIFT, S_ISHIFT_W, S_INSERT, S_RSHIFT, S_RSHIFT_W, S_RFIN,
		S_RD, S_RD_W,
		S_C_V, S_C_V_W, S_C_J, S_C_J_W, S_C_U_W, S_C_B, S_C_B_W,
		S_C_MX, S_C_MX_W, S_C_MY, S_C_MY_W, S_C_STORE, S_DONE
	} state_t;

	typedef struct packed {
		logic              adj_we;
		logic [ADDR_W-1:0] adj_waddr;
		logic [NODE_W-1:0] adj_wdata;
		logic [ADDR_W-1:0] adj_raddr;
		logic              len_we;
		logic [NODE_W-1:0] len_addr;
		logic [LEN_W-1:0]  len_wdata;
		logic              tri_we;
		logic [NODE_W-1:0] tri_addr;
		logic [CNT_W-1:0]  tri_wdata;
	} mem_req_t;

endpackage

/* hdl/sorted_adjacency_triangle_counter.sv */
// Top level of the sorted adjacency triangle counter.
// One sequencer drives a single compare unit over memories with one read port each.
// After reset a clearing pass over all 1024 nodes zeroes list lengths and node counts;
// no transaction is taken meanwhile. Add, remove and find scan the sorted list entry by
// entry; add and remove then shift the entries behind the position one by one. Count
// reads, per node v, the length of v and, per neighbor u, the length of u, scans u's list
// past u, then merges the rest of v's list with u's list. One transaction is in work at a
// time; a result waits in the output register until taken.
module sorted_adjacency_triangle_counter
	import satc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // mode[2:0], src_node[12:3], dst_node[22:13]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // status[2:0], position[8:3], triangle_count[30:9],
	                               // edge_total[47:31]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	state_t state_q, state_d;
	mem_req_t req;
	logic [NODE_W-1:0] adj_rd;
	logic [LEN_W-1:0]  len_rd;
	logic [CNT_W-1:0]  tri_rd;

	logic [NC_W-1:0]   node_count_q;
	logic [NODE_W-1:0] clr_q;
	logic [2:0]        mode_q;
	logic [NODE_W-1:0] src_q, dst_q, u_q, x_q;
	logic [LEN_W-1:0]  len_q, i_q, j_q, nv_q, nu_q, a_q, b_q;
	logic [NC_W-1:0]   v_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_q, tri_out_q;
	logic [2:0]        status_q;
	logic [IDX_W-1:0]  pos_q;
	logic [TOT_W-1:0]  entry_q;
	logic              out_valid_q;
	logic [47:0]       out_data_q;

	logic [2:0]        in_mode;
	logic [NODE_W-1:0] in_src, in_dst;
	logic [NC_W-1:0]   n_w;
	logic              src_oor, dst_oor, accept, out_load;
	logic [LEN_W-1:0]  jm1, jp1;
	logic [SUM_W:0]    sum_add;
	logic [SUM_W-1:0]  sum_next;

	assign in_mode  = s_tdata[2:0];
	assign in_src   = s_tdata[12:3];
	assign in_dst   = s_tdata[22:13];
	assign n_w      = (node_count_q > MAX_NODES) ? MAX_NODES : node_count_q;
	assign src_oor  = {1'b0, in_src} >= n_w;
	assign dst_oor  = {1'b0, in_dst} >= n_w;
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_tready);
	assign jm1      = j_q - 7'd1;
	assign jp1      = j_q + 7'd1;
	assign sum_add  = {1'b0, sum_q} + 23'(cnt_q);
	assign sum_next = (sum_add > {1'b0, TOTAL_SAT}) ? TOTAL_SAT : sum_add[SUM_W-1:0];

	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == 1'b0) ? 32'(node_count_q) : 32'd0;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	satc_store u_store (
		.clk       (clk),
		.req       (req),
		.adj_rdata (adj_rd),
		.len_rdata (len_rd),
		.tri_rdata (tri_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		req     = '0;
		case (state_q)
			S_CLEAR: begin
				req.len_we   = 1'b1;
				req.tri_we   = 1'b1;
				req.len_addr = clr_q;
				req.tri_addr = clr_q;
				if (clr_q == {NODE_W{1'b1}}) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					if (in_mode == MODE_ADD || in_mode == MODE_REMOVE
						|| in_mode == MODE_FIND) begin
						if (src_oor || dst_oor) state_d = S_DONE;
						else if (in_mode == MODE_ADD && in_src == in_dst) state_d = S_DONE;
						else state_d = S_LEN;
					end else if (in_mode == MODE_COUNT) begin
						state_d = (n_w == '0) ? S_DONE : S_C_V;
					end else if (in_mode == MODE_READ) begin
						state_d = src_oor ? S_DONE : S_RD;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_LEN: begin
				req.len_addr = src_q;
				state_d = S_LEN_W;
			end
			S_LEN_W: state_d = S_SCAN;
			S_SCAN: begin
				req.adj_raddr = {src_q, i_q[IDX_W-1:0]};
				if (i_q == len_q) begin
					if (mode_q == MODE_ADD && len_q != MAX_DEGREE) state_d = S_ISHIFT;
					else state_d = S_DONE;
				end else begin
					state_d = S_SCAN_W;
				end
			end
			S_SCAN_W: begin
				if (adj_rd == dst_q) begin
					if (mode_q == MODE_REMOVE) state_d = S_RSHIFT;
					else state_d = S_DONE;
				end else if (adj_rd > dst_q) begin
					if (mode_q == MODE_ADD && len_q != MAX_DEGREE) state_d = S_ISHIFT;
					else state_d = S_DONE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_ISHIFT: begin
				req.adj_raddr = {src_q, jm1[IDX_W-1:0]};
				state_d = (j_q == i_q) ? S_INSERT : S_ISHIFT_W;
			end
			S_ISHIFT_W: begin
				req.adj_we    = 1'b1;
				req.adj_waddr = {src_q, j_q[IDX_W-1:0]};
				req.adj_wdata = adj_rd;
				state_d = S_ISHIFT;
			end
			S_INSERT: begin
				req.adj_we    = 1'b1;
				req.adj_waddr = {src_q, i_q[IDX_W-1:0]};
				req.adj_wdata = dst_q;
				req.len_we    = 1'b1;
				req.len_addr  = src_q;
				req.len_wdata = len_q + 7'd1;
				state_d = S_DONE;
			end
			S_RSHIFT: begin
				req.adj_raddr = {src_q, jp1[IDX_W-1:0]};
				state_d = (jp1 >= len_q) ? S_RFIN : S_RSHIFT_W;
			end
			S_RSHIFT_W: begin
				req.adj_we    = 1'b1;
				req.adj_waddr = {src_q, j_q[IDX_W-1:0]};
				req.adj_wdata = adj_rd;
				state_d = S_RSHIFT;
			end
			S_RFIN: begin
				req.len_we    = 1'b1;
				req.len_addr  = src_q;
				req.len_wdata = len_q - 7'd1;
				state_d = S_DONE;
			end
			S_RD: begin
				req.tri_addr = src_q;
				state_d = S_RD_W;
			end
			S_RD_W: state_d = S_DONE;
			S_C_V: begin
				req.len_addr = v_q[NODE_W-1:0];
				state_d = S_C_V_W;
			end
			S_C_V_W: state_d = S_C_J;
			S_C_J: begin
				req.adj_raddr = {v_q[NODE_W-1:0], j_q[IDX_W-1:0]};
				state_d = (j_q == nv_q) ? S_C_STORE : S_C_J_W;
			end
			S_C_J_W: begin
				req.len_addr = adj_rd;
				state_d = S_C_U_W;
			end
			S_C_U_W: state_d = S_C_B;
			S_C_B: begin
				req.adj_raddr = {u_q, b_q[IDX_W-1:0]};
				state_d = (b_q == nu_q) ? S_C_MX : S_C_B_W;
			end
			S_C_B_W: state_d = (adj_rd > u_q) ? S_C_MX : S_C_B;
			S_C_MX: begin
				req.adj_raddr = {v_q[NODE_W-1:0], a_q[IDX_W-1:0]};
				state_d = (a_q == nv_q || b_q == nu_q) ? S_C_J : S_C_MX_W;
			end
			S_C_MX_W: state_d = S_C_MY;
			S_C_MY: begin
				req.adj_raddr = {u_q, b_q[IDX_W-1:0]};
				state_d = S_C_MY_W;
			end
			S_C_MY_W: state_d = S_C_MX;
			S_C_STORE: begin
				req.tri_we    = 1'b1;
				req.tri_addr  = v_q[NODE_W-1:0];
				req.tri_wdata = cnt_q;
				state_d = (v_q + 11'd1 == n_w) ? S_DONE : S_C_V;
			end
			S_DONE: begin
				if (out_load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= MAX_NODES;
			clr_q        <= '0;
			entry_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
				node_count_q <= pwdata[NC_W-1:0];
			end
			if (state_q == S_CLEAR) clr_q <= clr_q + 10'd1;
			if (state_q == S_INSERT) entry_q <= entry_q + 17'd1;
			if (state_q == S_RFIN && entry_q != '0) entry_q <= entry_q - 17'd1;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {entry_q, tri_out_q, pos_q, status_q};
		end
		case (state_q)
			S_IDLE: begin
				mode_q    <= in_mode;
				src_q     <= in_src;
				dst_q     <= in_dst;
				pos_q     <= '0;
				tri_out_q <= '0;
				sum_q     <= '0;
				v_q       <= '0;
				status_q  <= ST_OK;
				if (in_mode == MODE_ADD || in_mode == MODE_REMOVE || in_mode == MODE_FIND) begin
					if (src_oor || dst_oor) status_q <= ST_RANGE;
					else if (in_mode == MODE_ADD && in_src == in_dst) status_q <= ST_SELF;
				end else if (in_mode == MODE_READ && src_oor) begin
					status_q <= ST_RANGE;
				end
			end
			S_LEN_W: begin
				len_q <= len_rd;
				i_q   <= '0;
			end
			S_SCAN: begin
				j_q <= len_q;
				if (i_q == len_q) begin
					if (mode_q != MODE_ADD) status_q <= ST_NOTFOUND;
					else if (len_q == MAX_DEGREE) status_q <= ST_FULL;
				end
			end
			S_SCAN_W: begin
				if (adj_rd == dst_q) begin
					j_q <= i_q;
					if (mode_q == MODE_ADD) status_q <= ST_DUP;
					if (mode_q == MODE_FIND) pos_q <= i_q[IDX_W-1:0];
				end else if (adj_rd > dst_q) begin
					if (mode_q != MODE_ADD) status_q <= ST_NOTFOUND;
					else if (len_q == MAX_DEGREE) status_q <= ST_FULL;
				end else begin
					i_q <= i_q + 7'd1;
				end
			end
			S_ISHIFT_W: j_q <= jm1;
			S_RSHIFT_W: j_q <= jp1;
			S_RD_W: tri_out_q <= SUM_W'(tri_rd);
			S_C_V_W: begin
				nv_q  <= len_rd;
				j_q   <= '0;
				cnt_q <= '0;
			end
			S_C_J_W: u_q <= adj_rd;
			S_C_U_W: begin
				nu_q <= len_rd;
				a_q  <= jp1;
				b_q  <= '0;
			end
			S_C_B_W: begin
				if (!(adj_rd > u_q)) b_q <= b_q + 7'd1;
			end
			S_C_MX: begin
				if (a_q == nv_q || b_q == nu_q) j_q <= jp1;
			end
			S_C_MX_W: x_q <= adj_rd;
			S_C_MY_W: begin
				if (x_q == adj_rd) begin
					if (cnt_q != NODE_SAT) cnt_q <= cnt_q + 13'd1;
					a_q <= a_q + 7'd1;
					b_q <= b_q + 7'd1;
				end else if (x_q < adj_rd) begin
					a_q <= a_q + 7'd1;
				end else begin
					b_q <= b_q + 7'd1;
				end
			end
			S_C_STORE: begin
				sum_q     <= sum_next;
				tri_out_q <= sum_next;
				v_q       <= v_q + 11'd1;
			end
			default: begin
			end
		endcase
	end

endmodule

/* hdl/satc_store.sv */
// Adjacency, list length and per-node count memories with registered reads.
module satc_store
	import satc_pkg::*;
(
	input  logic              clk,
	input  mem_req_t          req,
	output logic [NODE_W-1:0] adj_rdata,
	output logic [LEN_W-1:0]  len_rdata,
	output logic [CNT_W-1:0]  tri_rdata
);

	logic [NODE_W-1:0] adj_mem [2**ADDR_W];
	logic [LEN_W-1:0]  len_mem [2**NODE_W];
	logic [CNT_W-1:0]  tri_mem [2**NODE_W];

	always_ff @(posedge clk) begin
		if (req.adj_we) begin
			adj_mem[req.adj_waddr] <= req.adj_wdata;
		end
		adj_rdata <= adj_mem[req.adj_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.len_we) begin
			len_mem[req.len_addr] <= req.len_wdata;
		end
		len_rdata <= len_mem[req.len_addr];
	end

	always_ff @(posedge clk) begin
		if (req.tri_we) begin
			tri_mem[req.tri_addr] <= req.tri_wdata;
		end
		tri_rdata <= tri_mem[req.tri_addr];
	end

endmodule
